[rtl/core/tsrel_pkg.sv]
// Shared constants, types and table helpers for the tick scheduler.
`default_nettype none

package tsrel_pkg;

  // Sizing of the task set and the time counters.
  localparam int SERVICES  = 4;
  localparam int TIME_BITS = 16;
  localparam int IDX_W     = (SERVICES > 1) ? $clog2(SERVICES) : 1;

  // Fixed widths of the item fields and configuration registers.
  localparam int RAN_W        = 2;
  localparam int MASK_W       = 4;
  localparam int OUT_METRIC_W = 17;
  localparam int MISS_W       = 32;
  localparam int POLICY_W     = 2;
  localparam int COUNT_W      = 3;
  localparam int TABLE_W      = 64;
  localparam int DATA_W       = 64;
  localparam int ADDR_W       = 5;
  localparam int REG_IDX_W    = ADDR_W - 3;

  // Internal metric is wide enough for a laxity and for the output field.
  localparam int METRIC_W = (TIME_BITS + 2 > OUT_METRIC_W) ? TIME_BITS + 2 : OUT_METRIC_W;

  // Scheduling policy codes; the unused code behaves as rate monotonic.
  localparam logic [POLICY_W-1:0] POL_RM  = 2'd0;
  localparam logic [POLICY_W-1:0] POL_EDF = 2'd1;
  localparam logic [POLICY_W-1:0] POL_LLF = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_POLICY = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COUNT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_WCET   = 2'd3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef time_t [SERVICES-1:0] time_vec_t;
  typedef logic signed [METRIC_W-1:0] metric_t;

  // Outcome of the selection step.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    metric_t          metric;
  } pick_t;

  // One task's field of a packed table; fields past the top read as zero.
  function automatic time_t table_field(input logic [TABLE_W-1:0] tbl, input int idx);
    logic [TABLE_W-1:0] shifted;
    shifted = '0;
    if (idx * TIME_BITS < TABLE_W) begin
      shifted = tbl >> (idx * TIME_BITS);
    end
    return shifted[TIME_BITS-1:0];
  endfunction

  // A period of zero counts as one tick.
  function automatic time_t period_of(input logic [TABLE_W-1:0] tbl, input int idx);
    time_t p;
    p = table_field(tbl, idx);
    return (p == '0) ? TIME_BITS'(1) : p;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tsrel_pick.sv]
// Selection of the task that receives the current slot.
`default_nettype none

module tsrel_pick import tsrel_pkg::*; (
  input  wire logic [POLICY_W-1:0] policy_i,
  input  wire logic [SERVICES-1:0] active_i,
  input  wire time_vec_t           deadline_i,
  input  wire time_vec_t           runtime_i,
  input  wire time_vec_t           wcet_i,
  output pick_t                    pick_o
);

  // Walk the tasks from the lowest index; a later task wins only on a strictly
  // smaller metric, and only under the deadline and laxity policies.
  always_comb begin
    metric_t          m;
    metric_t          best;
    logic             ready;
    logic             ranked;
    logic             found;
    logic [IDX_W-1:0] idx;
    best   = '0;
    found  = 1'b0;
    idx    = '0;
    ranked = (policy_i == POL_EDF) || (policy_i == POL_LLF);
    for (int s = 0; s < SERVICES; s++) begin
      ready = active_i[s] && (runtime_i[s] < wcet_i[s]);
      m     = metric_t'(deadline_i[s]);
      if (policy_i == POL_LLF) begin
        m = m - (metric_t'(wcet_i[s]) - metric_t'(runtime_i[s]));
      end
      if (ready && (!found || (ranked && (m < best)))) begin
        found = 1'b1;
        idx   = IDX_W'(s);
        best  = m;
      end
    end
    pick_o.found  = found;
    pick_o.idx    = idx;
    pick_o.metric = best;
  end

endmodule

`default_nettype wire

[rtl/core/tick_scheduler_rm_edf_llf_unit.sv]
// Top level of the periodic tick scheduler with RM, EDF and LLF policies.
// Tick items pass through the input register and the result register; one tick item per cycle
// while the output is not stalled. With the output stalled the block holds two items,
// one in the input register and one in the result register, and then stalls its input.
// The whole tick (expiry, selection, counter updates) is one combinational stage between them.
// Reset clears deadlines, runtimes and the miss total; policy 0, task count 4, tables 0.
`default_nettype none

module tick_scheduler_rm_edf_llf_unit import tsrel_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Tick items
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      start_req_i,
  // Result items
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [RAN_W-1:0]               ran_task_o,
  output logic                           idle_o,
  output logic [MASK_W-1:0]              miss_mask_o,
  output logic signed [OUT_METRIC_W-1:0] chosen_metric_o,
  output logic [MISS_W-1:0]              miss_total_o,
  // Configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ADDR_W-1:0]         paddr,
  input  wire logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]              prdata,
  output logic                           pready
);

  logic [POLICY_W-1:0] policy_q;
  logic [COUNT_W-1:0]  task_count_q;
  logic [TABLE_W-1:0]  period_q;
  logic [TABLE_W-1:0]  wcet_q;

  time_vec_t           deadline_q, deadline_d;
  time_vec_t           runtime_q, runtime_d;
  logic [MISS_W-1:0]   miss_q, miss_d;

  logic                in_valid_q;
  logic                start_q;
  logic                out_valid_q;

  logic                out_free;
  logic                advance;
  logic                accept_in;
  logic                cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;

  time_vec_t           period_v, wcet_v;
  time_vec_t           dl_start, rt_start;
  time_vec_t           dl_exp, rt_exp;
  logic [SERVICES-1:0] active;
  logic [SERVICES-1:0] miss_vec;
  pick_t               pick;
  logic [MISS_W:0]     miss_sum;

  // Configuration port: writes complete in the access phase, reads are direct.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:3];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_POLICY: prdata = DATA_W'(policy_q);
      REG_COUNT:  prdata = DATA_W'(task_count_q);
      REG_PERIOD: prdata = period_q;
      REG_WCET:   prdata = wcet_q;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= POL_RM;
      task_count_q <= COUNT_W'(4);
      period_q     <= '0;
      wcet_q       <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_POLICY: policy_q     <= pwdata[POLICY_W-1:0];
        REG_COUNT:  task_count_q <= pwdata[COUNT_W-1:0];
        REG_PERIOD: period_q     <= pwdata[TABLE_W-1:0];
        REG_WCET:   wcet_q       <= pwdata[TABLE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Handshake: the tick in the input register advances whenever the result
  // register is empty or is being taken in this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept_in  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_in) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      start_q <= start_req_i;
    end
  end

  // Start request and deadline expiry for every task.
  always_comb begin
    for (int s = 0; s < SERVICES; s++) begin
      period_v[s] = period_of(period_q, s);
      wcet_v[s]   = table_field(wcet_q, s);
      active[s]   = 32'(task_count_q) > s;
      dl_start[s] = start_q ? period_v[s] : deadline_q[s];
      rt_start[s] = start_q ? '0 : runtime_q[s];
      miss_vec[s] = 1'b0;
      dl_exp[s]   = dl_start[s];
      rt_exp[s]   = rt_start[s];
      if (active[s] && (dl_start[s] == '0)) begin
        dl_exp[s]   = period_v[s];
        miss_vec[s] = rt_start[s] < wcet_v[s];
        rt_exp[s]   = '0;
      end
    end
  end

  tsrel_pick u_pick (
    .policy_i   (policy_q),
    .active_i   (active),
    .deadline_i (dl_exp),
    .runtime_i  (rt_exp),
    .wcet_i     (wcet_v),
    .pick_o     (pick)
  );

  // Charge the slot to the chosen task, count down the active deadlines and
  // add this tick's misses to the saturating total.
  always_comb begin
    for (int s = 0; s < SERVICES; s++) begin
      runtime_d[s]  = rt_exp[s];
      if (pick.found && (pick.idx == IDX_W'(s))) begin
        runtime_d[s] = rt_exp[s] + TIME_BITS'(1);
      end
      deadline_d[s] = active[s] ? (dl_exp[s] - TIME_BITS'(1)) : dl_exp[s];
    end
    miss_sum = {1'b0, miss_q} + (MISS_W + 1)'($countones(miss_vec));
    miss_d   = miss_sum[MISS_W] ? '1 : miss_sum[MISS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= '0;
      runtime_q  <= '0;
      miss_q     <= '0;
    end else if (advance) begin
      deadline_q <= deadline_d;
      runtime_q  <= runtime_d;
      miss_q     <= miss_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ran_task_o      <= pick.found ? RAN_W'(pick.idx) : '0;
      idle_o          <= !pick.found;
      miss_mask_o     <= MASK_W'(miss_vec);
      chosen_metric_o <= pick.found ? pick.metric[OUT_METRIC_W-1:0] : '0;
      miss_total_o    <= miss_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An idle slot reports task zero and a zero metric.
  a_idle_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_o |-> (ran_task_o == '0) && (chosen_metric_o == '0))
    else $error("idle result carries a task or a metric");

  // The miss total never goes down.
  a_miss_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> miss_q >= $past(miss_q))
    else $error("miss total decreased");

  // Task state only moves when a tick is processed.
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(deadline_q) && $stable(runtime_q) && $stable(miss_q))
    else $error("task state changed without a tick");

  // A fresh result reports the miss total that the state now holds.
  a_total_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> miss_total_o == miss_q)
    else $error("reported miss total differs from the counter");

endmodule

`default_nettype wire
